### design/counting_semaphore_table_macros.svh
// Assertion helpers for the semaphore table RTL.
`ifndef COUNTING_SEMAPHORE_TABLE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while in reset.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### design/cst_pkg.sv
package cst_pkg;

  localparam int NUM_SEMS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(NUM_SEMS);

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 8;
  localparam int INIT_W   = 16;
  localparam int STATUS_W = 3;

  // Alloc only scans entries that granted_id can name.
  localparam int ID_LIMIT = 1 << ID_W;
  localparam int SCAN_N   = (NUM_SEMS < ID_LIMIT) ? NUM_SEMS : ID_LIMIT;
  localparam int GRP_N    = 16;
  localparam int GRP_W    = $clog2(GRP_N);
  localparam int NGRP     = (SCAN_N + GRP_N - 1) / GRP_N;

  localparam logic [FUNC_W-1:0] OP_ALLOC = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] OP_OPEN  = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] OP_CLOSE = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] OP_UP    = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] OP_DOWN  = FUNC_W'(4);

  localparam logic [STATUS_W-1:0] STAT_OK           = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_ALREADY_OPEN = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_CLOSED       = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STAT_WOULD_BLOCK  = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] STAT_NONE_FREE    = STATUS_W'(4);
  localparam logic [STATUS_W-1:0] STAT_FULL         = STATUS_W'(5);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   sem_id;
    logic [INIT_W-1:0] init_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     granted_id;
    logic                wake;
  } rsp_t;

  // Lowest closed entry among the scanned ones.
  typedef struct packed {
    logic found;
    idx_t idx;
  } scan_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Saturate an initial count to the counter width.
  function automatic count_t clamp_init(logic [INIT_W-1:0] v);
    if ((INIT_W + COUNT_BITS)'(v) > (INIT_W + COUNT_BITS)'(COUNT_MAX)) begin
      return COUNT_MAX;
    end
    return COUNT_BITS'(v);
  endfunction

endpackage

### design/cst_free_scan.sv
module cst_free_scan (
  input  logic                         clk,
  input  logic [cst_pkg::NUM_SEMS-1:0] open_flags,
  output cst_pkg::scan_t               scan
);
  import cst_pkg::*;

  logic [NGRP-1:0]  grp_free;
  logic [GRP_W-1:0] grp_low [NGRP];
  logic [NGRP-1:0]  grp_free_next;
  logic [GRP_W-1:0] grp_low_next [NGRP];

  // First level: lowest closed entry within each group of sixteen.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_free_next[g] = 1'b0;
      grp_low_next[g]  = '0;
      for (int j = GRP_N - 1; j >= 0; j--) begin
        if ((g * GRP_N + j) < SCAN_N) begin
          if (!open_flags[g * GRP_N + j]) begin
            grp_free_next[g] = 1'b1;
            grp_low_next[g]  = GRP_W'(j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free <= grp_free_next;
    for (int g = 0; g < NGRP; g++) begin
      grp_low[g] <= grp_low_next[g];
    end
  end

  // Second level: lowest group that holds a closed entry.
  always_comb begin
    scan.found = |grp_free;
    scan.idx   = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        scan.idx = IDX_W'(g * GRP_N + int'(grp_low[g]));
      end
    end
  end

endmodule

### design/counting_semaphore_table.sv
// Channel   Dir  Payload  Handshake
// request   in   req_t    req_valid / req_stall  (accepted when valid and not stall)
// response  out  rsp_t    rsp_valid / rsp_stall  (taken when valid and not stall)
//
// Every request passes through S_IDLE, which reads the count memory on accept and registers
// the free-entry scan, then S_EXEC, which modifies and writes back; the single-port count
// memory sets this split. Reset clears the open flags (all entries closed); counts need no
// clearing. A stalled response holds the request in S_EXEC; a new request is taken while
// an earlier response still waits in the output register.
`include "counting_semaphore_table_macros.svh"

module counting_semaphore_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cst_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cst_pkg::rsp_t rsp_data
);
  import cst_pkg::*;

  state_t state;
  state_t state_next;

  req_t   req;
  idx_t   req_idx;
  logic   id_ok;

  // Open flags live in flops so reset closes every entry at once.
  logic [NUM_SEMS-1:0] open_flags;
  // Counts live in a synchronous memory; a read value is only used while the entry is open.
  count_t counts [NUM_SEMS];
  count_t rd_count;

  scan_t  scan;

  logic   req_acc;
  logic   slot_free;
  logic   load;
  rsp_t   rsp_next;
  logic   mod_en;
  idx_t   wr_idx;
  count_t wr_count;
  logic   flag_set;
  logic   flag_clr;

  cst_free_scan u_scan (
    .clk        (clk),
    .open_flags (open_flags),
    .scan       (scan)
  );

  assign req_acc   = req_valid && !req_stall;
  // Output register can take a response if empty or being drained this cycle.
  assign slot_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // Hold here until the response register frees up; commit on the way out.
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      req <= req_data;
    end
  end

  // Count memory: read on accept, write back when the request commits. The write always
  // lands before the next read, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      rd_count <= counts[IDX_W'(req_data.sem_id)];
    end
    if (load && mod_en) begin
      counts[wr_idx] <= wr_count;
    end
  end

  assign req_idx = IDX_W'(req.sem_id);
  assign id_ok   = 32'(req.sem_id) < 32'(NUM_SEMS);

  // Decide the result and the entry update.
  always_comb begin
    rsp_next.status     = STAT_OK;
    rsp_next.granted_id = '0;
    rsp_next.wake       = 1'b0;
    mod_en              = 1'b0;
    wr_idx              = req_idx;
    wr_count            = rd_count;
    flag_set            = 1'b0;
    flag_clr            = 1'b0;
    priority if (req.func == OP_ALLOC) begin
      if (scan.found) begin
        wr_idx              = scan.idx;
        wr_count            = clamp_init(req.init_count);
        mod_en              = 1'b1;
        flag_set            = 1'b1;
        rsp_next.granted_id = ID_W'(scan.idx);
      end else begin
        rsp_next.status = STAT_NONE_FREE;
      end
    end else if (req.func > OP_DOWN || !id_ok) begin
      rsp_next.status = STAT_CLOSED;
    end else if (req.func == OP_OPEN) begin
      if (open_flags[req_idx]) begin
        rsp_next.status = STAT_ALREADY_OPEN;
      end else begin
        wr_count = clamp_init(req.init_count);
        mod_en   = 1'b1;
        flag_set = 1'b1;
      end
    end else if (req.func == OP_CLOSE) begin
      flag_clr = 1'b1;
    end else if (!open_flags[req_idx]) begin
      rsp_next.status = STAT_CLOSED;
    end else if (req.func == OP_UP) begin
      if (rd_count == COUNT_MAX) begin
        rsp_next.status = STAT_FULL;
      end else begin
        rsp_next.wake = (rd_count == '0);
        wr_count      = rd_count + COUNT_BITS'(1);
        mod_en        = 1'b1;
      end
    end else begin
      // Down at zero stands in for sleeping: report and leave the entry alone.
      if (rd_count == '0) begin
        rsp_next.status = STAT_WOULD_BLOCK;
      end else begin
        wr_count = rd_count - COUNT_BITS'(1);
        mod_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_flags <= '0;
    end else if (load && flag_set) begin
      open_flags[wr_idx] <= 1'b1;
    end else if (load && flag_clr) begin
      open_flags[wr_idx] <= 1'b0;
    end
  end

  // Output register: a new response overrides the drain of the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data <= rsp_next;
    end
  end

  `CST_ASSERT_NEXT(a_commit_returns_idle, clk, rst, state == S_EXEC && slot_free, state == S_IDLE)
  `CST_ASSERT_NEXT(a_alloc_opens_entry, clk, rst, load && req.func == OP_ALLOC && scan.found, open_flags[$past(scan.idx)])
  `CST_ASSERT_IMPL(a_none_free_all_open, clk, rst, load && rsp_next.status == STAT_NONE_FREE, &open_flags[SCAN_N-1:0])
  `CST_ASSERT_IMPL(a_wake_only_on_ok, clk, rst, rsp_valid && rsp_data.wake, rsp_data.status == STAT_OK)

endmodule

### sim/counting_semaphore_table_check.sv
`timescale 1ns / 1ps

module counting_semaphore_table_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  cst_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  cst_pkg::rsp_t rsp_data,
  output int            mismatch_count,
  output int            pending_responses
);
  import cst_pkg::*;

  logic [NUM_SEMS-1:0] shadow_open;
  count_t              sem_count [NUM_SEMS];
  rsp_t                expected_responses [$];

  // Apply one request to the shadow table and return the response it earns.
  function automatic rsp_t apply_semaphore_op(req_t r);
    rsp_t   res;
    count_t start;
    int     idx;
    res = '0;
    res.status = STAT_OK;
    idx = int'(r.sem_id);
    start = (longint'(r.init_count) > longint'(COUNT_MAX)) ? COUNT_MAX : count_t'(r.init_count);
    case (r.func)
      OP_ALLOC: begin
        res.status = STAT_NONE_FREE;
        for (int i = 0; i < SCAN_N; i++) begin
          if (!shadow_open[i]) begin
            shadow_open[i] = 1'b1;
            sem_count[i] = start;
            res.status = STAT_OK;
            res.granted_id = ID_W'(i);
            break;
          end
        end
      end
      OP_OPEN: begin
        if (idx >= NUM_SEMS) begin
          res.status = STAT_CLOSED;
        end else if (shadow_open[idx]) begin
          res.status = STAT_ALREADY_OPEN;
        end else begin
          shadow_open[idx] = 1'b1;
          sem_count[idx] = start;
        end
      end
      OP_CLOSE: begin
        if (idx >= NUM_SEMS) begin
          res.status = STAT_CLOSED;
        end else begin
          shadow_open[idx] = 1'b0;
        end
      end
      OP_UP, OP_DOWN: begin
        if (idx >= NUM_SEMS || !shadow_open[idx]) begin
          res.status = STAT_CLOSED;
        end else if (r.func == OP_UP) begin
          if (sem_count[idx] == COUNT_MAX) begin
            res.status = STAT_FULL;
          end else begin
            res.wake = (sem_count[idx] == '0);
            sem_count[idx] = sem_count[idx] + 1'b1;
          end
        end else if (sem_count[idx] == '0) begin
          res.status = STAT_WOULD_BLOCK;
        end else begin
          sem_count[idx] = sem_count[idx] - 1'b1;
        end
      end
      default: begin
        res.status = STAT_CLOSED;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_open = '0;
      expected_responses.delete();
      mismatch_count = 0;
    end else begin
      // Retire the response first so a stray one never matches this cycle's request.
      if (rsp_valid && !rsp_stall) begin
        if (expected_responses.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_responses.pop_front();
          if (rsp_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_data.status);
            mismatch_count++;
          end
          if (rsp_data.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id, rsp_data.granted_id);
            mismatch_count++;
          end
          if (rsp_data.wake !== want.wake) begin
            $error("wake: expected %0d, got %0d", want.wake, rsp_data.wake);
            mismatch_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_responses.push_back(apply_semaphore_op(req_data));
      end
    end
    pending_responses = expected_responses.size();
  end

endmodule

### sim/counting_semaphore_table_test.sv
`timescale 1ns / 1ps

module counting_semaphore_table_test;
  import cst_pkg::*;

  // Cycles without any handshake before the run is declared hung; far above the
  // longest chain of sender gaps and response stalls.
  localparam int STALL_LIMIT = 4000;
  // Cycles to watch for stray responses once the last one has arrived.
  localparam int SETTLE_CYCLES = 8;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req_data = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp_data;

  bit    idling_on = 1'b0;
  int    stall_left = 0;
  int    idle_cycles = 0;
  int    mismatch_count;
  int    pending_responses;

  always #6 clk = ~clk;

  counting_semaphore_table dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  counting_semaphore_table_check u_check (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .req_data          (req_data),
    .rsp_valid         (rsp_valid),
    .rsp_stall         (rsp_stall),
    .rsp_data          (rsp_data),
    .mismatch_count    (mismatch_count),
    .pending_responses (pending_responses)
  );

  // Response backpressure: start a burst of stalled cycles now and then,
  // drop it at once when idling is switched off.
  always @(negedge clk) begin
    if (!idling_on) begin
      stall_left = 0;
      rsp_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog: count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                    logic [INIT_W-1:0] cnt);
    req_t r;
    r.func = f;
    r.sem_id = id;
    r.init_count = cnt;
    return r;
  endfunction

  // Favor counts at the edges so would-block, wake and full come up often.
  function automatic logic [INIT_W-1:0] pick_count();
    logic [INIT_W-1:0] c;
    case ($urandom_range(0, 5))
      0:       c = '0;
      1:       c = INIT_W'(1);
      2:       c = '1;
      3:       c = ~INIT_W'(1);
      default: c = INIT_W'($urandom);
    endcase
    return c;
  endfunction

  // Mostly well-formed traffic on ids base..base+span-1, with some raw noise
  // that covers the unused operation codes and any id or count.
  function automatic req_t random_request(logic [ID_W-1:0] base, int span);
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    r.sem_id = base + ID_W'($urandom_range(0, span - 1));
    r.init_count = pick_count();
    if (roll < 10) begin
      r.func = FUNC_W'($urandom_range(0, 7));
      r.sem_id = ID_W'($urandom);
      r.init_count = INIT_W'($urandom);
    end else if (roll < 17) begin
      r.func = OP_ALLOC;
    end else if (roll < 32) begin
      r.func = OP_OPEN;
    end else if (roll < 40) begin
      r.func = OP_CLOSE;
    end else if (roll < 70) begin
      r.func = OP_UP;
    end else begin
      r.func = OP_DOWN;
    end
    return r;
  endfunction

  // Present one request from a falling edge, hold it until taken, and return
  // on the falling edge after acceptance. Valid is only lowered for a gap.
  task automatic issue_request(input req_t r);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] base;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idling_on = 1'b1;

    // Directed: closed entries, a full count cycle on entry 0, saturation on
    // the top entry, reopen and close of an already-closed entry, and lowest-free reuse.
    issue_request(make_req(OP_DOWN,  ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_UP,    ID_W'(255),  '1));
    issue_request(make_req(OP_ALLOC, ID_W'(8'hAA), INIT_W'(0)));
    issue_request(make_req(OP_DOWN,  ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_UP,    ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_UP,    ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_DOWN,  ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_DOWN,  ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_DOWN,  ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_OPEN,  ID_W'(255),  '1));
    issue_request(make_req(OP_UP,    ID_W'(255),  INIT_W'(0)));
    issue_request(make_req(OP_OPEN,  ID_W'(255),  INIT_W'(16'h5555)));
    issue_request(make_req(OP_DOWN,  ID_W'(255),  INIT_W'(0)));
    issue_request(make_req(OP_UP,    ID_W'(255),  INIT_W'(0)));
    issue_request(make_req(OP_CLOSE, ID_W'(255),  INIT_W'(0)));
    issue_request(make_req(OP_CLOSE, ID_W'(255),  INIT_W'(0)));
    issue_request(make_req(OP_ALLOC, ID_W'(8'h55), '1));
    issue_request(make_req(OP_OPEN,  ID_W'(0),    INIT_W'(16'hAAAA)));
    issue_request(make_req(OP_OPEN,  ID_W'(128),  INIT_W'(16'h8000)));
    issue_request(make_req(OP_UP,    ID_W'(128),  INIT_W'(0)));
    issue_request(make_req(OP_ALLOC, ID_W'(255),  INIT_W'(1)));
    // Unused operation codes sit just above down.
    for (int k = 1; k <= 3; k++) begin
      issue_request(make_req(OP_DOWN + FUNC_W'(k), ID_W'(k * 100), INIT_W'($urandom)));
    end
    issue_request(make_req(OP_CLOSE, ID_W'(0),    INIT_W'(0)));
    issue_request(make_req(OP_ALLOC, ID_W'(0),    INIT_W'(16'h7FFF)));

    // Hot windows: a few neighboring entries opened, counted up and down, closed.
    for (int w = 0; w < 2; w++) begin
      idling_on = ($urandom_range(0, 3) != 0);
      base = ID_W'($urandom);
      repeat (20) issue_request(random_request(base, 8));
    end

    // Fill the table through alloc; the tail of this run hits none-free.
    idling_on = 1'b1;
    repeat (260) issue_request(make_req(OP_ALLOC, ID_W'($urandom), pick_count()));

    // Churn on a nearly full table: closes punch holes, allocs refill the lowest.
    for (int w = 0; w < 4; w++) begin
      idling_on = ($urandom_range(0, 3) != 0);
      base = ID_W'($urandom);
      repeat (12) issue_request(random_request(base, (w % 2 == 0) ? 256 : 8));
    end

    // Last stretch with neither side idling.
    idling_on = 1'b0;
    base = ID_W'($urandom);
    repeat (30) issue_request(random_request(base, 8));
    req_valid <= 1'b0;

    // Drain, then watch a little longer for anything unexpected.
    while (pending_responses != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_responses == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### counting_semaphore_table.f
+incdir+design
design/cst_pkg.sv
design/cst_free_scan.sv
design/counting_semaphore_table.sv
sim/counting_semaphore_table_check.sv
sim/counting_semaphore_table_test.sv
